@@ hw/rtl/tjpu_pkg.sv @@
// ----------------------------------------------------------------------------
// TinyJAMBU permutation unit package
// Shared widths, register indexes, the controller-to-datapath command type
// and the 32-step group update function.
// ----------------------------------------------------------------------------
package tjpu_pkg;

   localparam int WORD_W   = 32;
   localparam int HALF_W   = 64;
   localparam int ROUND_W  = 8;
   localparam int GROUP_W  = 2;
   localparam int KIDX_W   = 3;
   localparam int CSR_IDX_W = 3;
   localparam int KSIZE_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_SIZE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_01   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_23   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_45   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_67   = 3'd4;

   localparam logic [KSIZE_W-1:0] KSIZE_128 = 2'd0;
   localparam logic [KSIZE_W-1:0] KSIZE_192 = 2'd1;

   localparam logic [KIDX_W-1:0] KLAST_128 = 3'd3;
   localparam logic [KIDX_W-1:0] KLAST_192 = 3'd5;
   localparam logic [KIDX_W-1:0] KLAST_256 = 3'd7;

   typedef struct packed {
      logic load;
      logic advance;
   } cmd_type;

   function automatic logic [WORD_W-1:0] group_update(
      input logic [WORD_W-1:0] a,
      input logic [WORD_W-1:0] b,
      input logic [WORD_W-1:0] c,
      input logic [WORD_W-1:0] d,
      input logic [WORD_W-1:0] k
   );
      logic [WORD_W-1:0] t1;
      logic [WORD_W-1:0] t2;
      logic [WORD_W-1:0] t3;
      logic [WORD_W-1:0] t4;
      t1 = {c[14:0], b[31:15]};
      t2 = {d[5:0],  c[31:6]};
      t3 = {d[20:0], c[31:21]};
      t4 = {d[26:0], c[31:27]};
      return a ^ t1 ^ ~(t2 & t3) ^ t4 ^ k;
   endfunction

endpackage

@@ hw/rtl/tjpu_ctrl.sv @@
// ----------------------------------------------------------------------------
// TinyJAMBU permutation controller
// Sequences load, one group update per cycle over all rounds, and the
// result strobe.
// ----------------------------------------------------------------------------
module tjpu_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tjpu_pkg::ROUND_W-1:0]  req_round_count,
   output logic                          busy,
   output logic                          rsp_valid,
   output tjpu_pkg::cmd_type             cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                        state_ff;
   logic [1:0]                        state_in;
   logic [tjpu_pkg::ROUND_W-1:0]      rounds_ff;
   logic [tjpu_pkg::ROUND_W-1:0]      rounds_in;
   logic [tjpu_pkg::GROUP_W-1:0]      group_ff;
   logic [tjpu_pkg::GROUP_W-1:0]      group_in;
   logic                              accept;

   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      rounds_in   = rounds_ff;
      group_in    = group_ff;
      cmd.load    = 1'b0;
      cmd.advance = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load  = 1'b1;
               rounds_in = req_round_count;
               group_in  = '0;
               state_in  = (req_round_count == '0) ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.advance = 1'b1;
            group_in    = group_ff + 2'd1;
            if (group_ff == '1) begin
               rounds_in = rounds_ff - 8'd1;
               if (rounds_ff == 8'd1) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rounds_ff <= '0;
         group_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         rounds_ff <= rounds_in;
         group_ff  <= group_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

@@ hw/rtl/tjpu_datapath.sv @@
// ----------------------------------------------------------------------------
// TinyJAMBU permutation datapath
// Key registers, key size and word index, and the rotating state register
// that takes one 32-step group update per advance.
// ----------------------------------------------------------------------------
module tjpu_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  tjpu_pkg::cmd_type              cmd,
   input  logic                           csr_we,
   input  logic [tjpu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tjpu_pkg::HALF_W-1:0]    csr_wdata,
   input  logic [tjpu_pkg::HALF_W-1:0]    req_state_lower,
   input  logic [tjpu_pkg::HALF_W-1:0]    req_state_upper,
   output logic [tjpu_pkg::HALF_W-1:0]    rsp_result_lower,
   output logic [tjpu_pkg::HALF_W-1:0]    rsp_result_upper
);

   logic [tjpu_pkg::KSIZE_W-1:0]  key_size_ff;
   logic [tjpu_pkg::WORD_W-1:0]   key_ff [8];
   logic [tjpu_pkg::KIDX_W-1:0]   kidx_ff;
   logic [tjpu_pkg::KIDX_W-1:0]   kidx_in;
   logic [tjpu_pkg::KIDX_W-1:0]   klast;
   logic [tjpu_pkg::WORD_W-1:0]   s_ff [4];
   logic [tjpu_pkg::WORD_W-1:0]   s_in [4];
   logic [tjpu_pkg::WORD_W-1:0]   s_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff <= '0;
         for (int i = 0; i < 8; i++) begin
            key_ff[i] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            tjpu_pkg::CSR_KEY_SIZE: key_size_ff <= csr_wdata[tjpu_pkg::KSIZE_W-1:0];
            tjpu_pkg::CSR_KEY_01: begin
               key_ff[0] <= csr_wdata[31:0];
               key_ff[1] <= csr_wdata[63:32];
            end
            tjpu_pkg::CSR_KEY_23: begin
               key_ff[2] <= csr_wdata[31:0];
               key_ff[3] <= csr_wdata[63:32];
            end
            tjpu_pkg::CSR_KEY_45: begin
               key_ff[4] <= csr_wdata[31:0];
               key_ff[5] <= csr_wdata[63:32];
            end
            tjpu_pkg::CSR_KEY_67: begin
               key_ff[6] <= csr_wdata[31:0];
               key_ff[7] <= csr_wdata[63:32];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (key_size_ff)
         tjpu_pkg::KSIZE_128: klast = tjpu_pkg::KLAST_128;
         tjpu_pkg::KSIZE_192: klast = tjpu_pkg::KLAST_192;
         default:             klast = tjpu_pkg::KLAST_256;
      endcase
   end

   assign s_new = tjpu_pkg::group_update(s_ff[0], s_ff[1], s_ff[2], s_ff[3],
                                         key_ff[kidx_ff]);

   // Rotate after each group so the word being updated always sits in slot 0
   always_comb begin
      kidx_in = kidx_ff;
      s_in    = s_ff;
      if (cmd.load) begin
         kidx_in = '0;
         s_in[0] = req_state_lower[31:0];
         s_in[1] = req_state_lower[63:32];
         s_in[2] = req_state_upper[31:0];
         s_in[3] = req_state_upper[63:32];
      end else if (cmd.advance) begin
         kidx_in = (kidx_ff == klast) ? '0 : kidx_ff + 3'd1;
         s_in[0] = s_ff[1];
         s_in[1] = s_ff[2];
         s_in[2] = s_ff[3];
         s_in[3] = s_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kidx_ff <= '0;
      end else begin
         kidx_ff <= kidx_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
   end

   assign rsp_result_lower = {s_ff[1], s_ff[0]};
   assign rsp_result_upper = {s_ff[3], s_ff[2]};

endmodule

@@ hw/rtl/tinyjambu_permutation_unit.sv @@
// ----------------------------------------------------------------------------
// TinyJAMBU permutation unit
// A request with R rounds runs in the run state (skipped for R = 0) and then
// raises the result strobe in the done state, for R = 0 in the cycle after
// the accepting edge; busy stays high until the strobe cycle ends, so a new
// request is accepted only after the strobe. The group update does 32 steps
// per cycle. The strobe lasts one cycle and cannot be held off; configuration
// writes are always ready; the user must keep them to idle periods, as the unit does not enforce it.
// ----------------------------------------------------------------------------
module tinyjambu_permutation_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [tjpu_pkg::HALF_W-1:0]    req_state_lower,
   input  logic [tjpu_pkg::HALF_W-1:0]    req_state_upper,
   input  logic [tjpu_pkg::ROUND_W-1:0]   req_round_count,
   output logic                           rsp_valid,
   output logic [tjpu_pkg::HALF_W-1:0]    rsp_result_lower,
   output logic [tjpu_pkg::HALF_W-1:0]    rsp_result_upper,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tjpu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tjpu_pkg::HALF_W-1:0]    csr_wdata
);

   tjpu_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   tjpu_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_round_count (req_round_count),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .cmd             (cmd)
   );

   tjpu_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_we           (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_state_lower  (req_state_lower),
      .req_state_upper  (req_state_upper),
      .rsp_result_lower (rsp_result_lower),
      .rsp_result_upper (rsp_result_upper)
   );

endmodule

@@ hw/rtl/tjpu_checker.sv @@
// ----------------------------------------------------------------------------
// TinyJAMBU permutation unit checker
// Port-level checks on the request, busy and result strobe sequencing.
// ----------------------------------------------------------------------------
module tjpu_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic [tjpu_pkg::ROUND_W-1:0]   req_round_count,
   input logic                           rsp_valid
);

   a_strobe_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside busy period");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_idle_after_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("busy held after result strobe");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted without going busy");

   a_zero_rounds: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_round_count == '0) |=> rsp_valid)
      else $error("zero-round request not answered in next cycle");

endmodule

bind tinyjambu_permutation_unit tjpu_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_round_count (req_round_count),
   .rsp_valid       (rsp_valid)
);
